// ===== rtl/byte_stream_tokenizer_macros.svh =====
// Assertion macros shared by the tokenizer checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef BYTE_STREAM_TOKENIZER_MACROS_SVH
`define BYTE_STREAM_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BST_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer check failed");

// Next-cycle implication, disabled during reset
`define BST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed");

`endif

// ===== rtl/bst_pkg.sv =====
// Shared types, constants and character classes for the byte stream tokenizer.
// No dependencies.
package bst_pkg;

	localparam int POSITION_BITS = 16;
	localparam int FIELD_BITS    = 16;
	localparam int OUT_BYTES     = 4;
	localparam int OUT_BITS      = OUT_BYTES * 8;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_QUOTE = 8'h22;
	localparam logic [7:0] CHAR_UNDER = 8'h5F;

	typedef enum logic [1:0] {
		KIND_UNKNOWN = 2'd0,
		KIND_LITERAL = 2'd1,
		KIND_IDENT   = 2'd2,
		KIND_CONTROL = 2'd3
	} kind_t;

	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [FIELD_BITS-1:0]    len_t;

	typedef struct packed {
		kind_t                 kind;
		logic [FIELD_BITS-1:0] start;
		len_t                  length;
		logic                  last;
	} token_t;

	// Tokens produced by one byte: count and up to two slots, slot 0 first
	typedef struct packed {
		logic [1:0] count;
		token_t     tok0;
		token_t     tok1;
	} emit_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == CHAR_UNDER);
	endfunction

	// Low field bits of a position, zero-extended for narrow positions
	function automatic logic [FIELD_BITS-1:0] pos_to_start(input pos_t p);
		logic [31:0] wide;
		wide = 32'(p);
		return wide[FIELD_BITS-1:0];
	endfunction

endpackage

// ===== rtl/bst_scanner.sv =====
// Tokenizer scan state and per-byte token generation.
// Depends on bst_pkg.
module bst_scanner (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          text_byte,
	output bst_pkg::emit_t      emit
);

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_NUMBER = 2'd1,
		MODE_STRING = 2'd2,
		MODE_IDENT  = 2'd3
	} mode_t;

	mode_t         mode_q, mode_d;
	bst_pkg::pos_t start_q, start_d;
	bst_pkg::len_t len_q, len_d;
	bst_pkg::pos_t pos_q, pos_d;

	bst_pkg::len_t   grown;
	logic            done;
	logic            va, vb;
	bst_pkg::token_t ta, tb;

	assign grown = (len_q != '1) ? len_q + bst_pkg::len_t'(1) : len_q;

	// Close or extend the open token, then scan the byte as idle if needed
	always_comb begin
		mode_d  = mode_q;
		start_d = start_q;
		len_d   = len_q;
		done    = 1'b0;
		va      = 1'b0;
		vb      = 1'b0;
		ta      = '{kind: bst_pkg::KIND_UNKNOWN, start: bst_pkg::pos_to_start(start_q),
			length: len_q, last: 1'b0};
		tb      = '{kind: bst_pkg::KIND_UNKNOWN, start: bst_pkg::pos_to_start(pos_q),
			length: bst_pkg::len_t'(1), last: 1'b0};

		unique case (mode_q)
			MODE_NUMBER: begin
				if (bst_pkg::is_digit(text_byte)) begin
					len_d = grown;
					done  = 1'b1;
				end else begin
					va      = 1'b1;
					ta.kind = bst_pkg::KIND_LITERAL;
					mode_d  = MODE_IDLE;
				end
			end
			MODE_IDENT: begin
				if (bst_pkg::is_word(text_byte)) begin
					len_d = grown;
					done  = 1'b1;
				end else begin
					va      = 1'b1;
					ta.kind = bst_pkg::KIND_IDENT;
					mode_d  = MODE_IDLE;
				end
			end
			MODE_STRING: begin
				priority if (text_byte == bst_pkg::CHAR_QUOTE) begin
					va      = 1'b1;
					ta.kind = bst_pkg::KIND_LITERAL;
					mode_d  = MODE_IDLE;
					done    = 1'b1;
				end else if (text_byte == bst_pkg::CHAR_NUL) begin
					va      = 1'b1;
					ta.kind = bst_pkg::KIND_UNKNOWN;
					mode_d  = MODE_IDLE;
				end else begin
					len_d = grown;
					done  = 1'b1;
				end
			end
			MODE_IDLE: begin
			end
			default: begin
			end
		endcase

		if (!done) begin
			priority if (text_byte == bst_pkg::CHAR_NUL) begin
				vb      = 1'b1;
				tb.kind = bst_pkg::KIND_CONTROL;
			end else if (bst_pkg::is_space(text_byte)) begin
			end else if (bst_pkg::is_digit(text_byte)) begin
				mode_d  = MODE_NUMBER;
				start_d = pos_q;
				len_d   = bst_pkg::len_t'(1);
			end else if (text_byte == bst_pkg::CHAR_QUOTE) begin
				mode_d  = MODE_STRING;
				start_d = pos_q + bst_pkg::pos_t'(1);
				len_d   = '0;
			end else if (bst_pkg::is_alpha(text_byte) || (text_byte == bst_pkg::CHAR_UNDER)) begin
				mode_d  = MODE_IDENT;
				start_d = pos_q;
				len_d   = bst_pkg::len_t'(1);
			end else begin
				vb      = 1'b1;
				tb.kind = bst_pkg::KIND_UNKNOWN;
			end
		end

		// End of text starts a fresh text
		if (text_byte == bst_pkg::CHAR_NUL) begin
			mode_d  = MODE_IDLE;
			start_d = '0;
			len_d   = '0;
			pos_d   = '0;
		end else begin
			pos_d   = pos_q + bst_pkg::pos_t'(1);
		end
	end

	// Pack emitted tokens into slots and mark the final one
	always_comb begin
		emit.count = {1'b0, va} + {1'b0, vb};
		emit.tok0  = va ? ta : tb;
		emit.tok1  = tb;
		emit.tok0.last = !(va && vb);
		emit.tok1.last = 1'b1;
	end

	// Hold scan state; advance once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			start_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			start_q <= start_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
		end
	end

endmodule

// ===== rtl/bst_out_fifo.sv =====
// Result queue: takes up to two tokens a cycle, delivers one beat a cycle while out_ready is high.
// Depends on bst_pkg.
module bst_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bst_pkg::emit_t  emit,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output bst_pkg::token_t out_token
);

	localparam int PB = bst_pkg::FIFO_PTR_BITS;
	localparam int CB = bst_pkg::FIFO_CNT_BITS;

	bst_pkg::token_t mem_q [bst_pkg::FIFO_DEPTH];
	logic [PB-1:0]   wr_q, rd_q;
	logic [CB-1:0]   count_q;
	logic [1:0]      n_push;
	logic            pop;

	assign n_push    = push ? emit.count : 2'd0;
	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_token = mem_q[rd_q];
	assign room      = (count_q <= CB'(bst_pkg::FIFO_DEPTH - 2));

	// Store new tokens at the write pointer
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_q] <= emit.tok0;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_q + PB'(1)] <= emit.tok1;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PB'(n_push);
			if (pop) begin
				rd_q <= rd_q + PB'(1);
			end
			count_q <= count_q + CB'(n_push) - CB'(pop);
		end
	end

endmodule

// ===== rtl/byte_stream_tokenizer.sv =====
// Byte stream tokenizer top level: input register, scanner and result queue.
// Depends on bst_pkg, bst_scanner and bst_out_fifo.
//
//  channel  direction  fields (low bit up)
//  s_*      in         tdata: text_byte[7:0]
//  m_*      out        tdata: token_start[15:0], token_length[31:16];
//                      tuser: token_kind[1:0]; tlast: last_of_run
//
// One byte is accepted per cycle; its tokens go to the result queue. Output delivers
// one beat per cycle while ready, so a byte that closes a token and is itself a
// token (two results) gives two output beats; the four-entry queue sets the stall.
// Input stalls when the registered byte cannot move because fewer than two queue
// entries are free. Reset clears scan state and empties the queue; no clearing pass.
module byte_stream_tokenizer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // text_byte[7:0]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [bst_pkg::OUT_BITS-1:0] m_tdata,   // token_start[15:0], token_length[31:16]
	output logic [1:0]                   m_tuser,   // token_kind[1:0]
	output logic                         m_tlast    // last_of_run
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            advance;
	logic            room;
	bst_pkg::emit_t  emit;
	bst_pkg::token_t head;

	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || advance;

	// Input register: hold the byte until the queue has room for its tokens
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	bst_scanner u_scanner (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.text_byte (byte_s1),
		.emit      (emit)
	);

	bst_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.emit      (emit),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_token (head)
	);

	// Pack the head token into the beat
	assign m_tdata = {head.length, head.start};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

// ===== rtl/bst_checker.sv =====
// Port-level checks for the byte stream tokenizer, bound to the top level.
// Depends on bst_pkg and byte_stream_tokenizer_macros.svh.
`include "byte_stream_tokenizer_macros.svh"

module bst_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [bst_pkg::OUT_BITS-1:0] m_tdata,
	input logic [1:0]                   m_tuser,
	input logic                         m_tlast
);

	logic is_control;
	logic one_long;

	assign is_control = (m_tuser == bst_pkg::KIND_CONTROL);
	assign one_long   = (m_tdata[31:16] == 16'd1);

	// A stalled beat stays offered
	`BST_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)

	// A stalled beat keeps its payload
	`BST_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable({m_tdata, m_tuser, m_tlast}))

	// End of text is always the final token of its byte and one byte long
	`BST_ASSERT_NOW(a_control, m_tvalid && is_control, m_tlast && one_long)

endmodule

bind byte_stream_tokenizer bst_checker u_bst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== sim/byte_stream_tokenizer_tb.sv =====
// Self-checking testbench for the byte stream tokenizer: streams text bytes in,
// predicts every token beat and compares it with the output stream.
// Depends on bst_pkg and the byte_stream_tokenizer RTL.
`timescale 1ns / 1ps

module byte_stream_tokenizer_tb;

	localparam int            WATCHDOG_LIMIT = 4000;
	localparam int            DRAIN_CYCLES   = 8;
	localparam int            RANDOM_BYTES   = 1000;
	localparam bst_pkg::len_t LEN_SAT        = '1;

	typedef enum logic [1:0] {
		SCAN_IDLE   = 2'd0,
		SCAN_NUMBER = 2'd1,
		SCAN_STRING = 2'd2,
		SCAN_IDENT  = 2'd3
	} scan_mode_t;

	typedef enum int {
		CC_NUL,
		CC_SPACE,
		CC_DIGIT,
		CC_QUOTE,
		CC_WORD,
		CC_OTHER
	} char_class_t;

	typedef enum int {
		RX_FREE,
		RX_HALF,
		RX_SPARSE,
		RX_BUSY
	} rx_style_t;

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [7:0]                   s_tdata;    // text_byte[7:0]
	logic                         m_tvalid;
	logic                         m_tready;
	logic [bst_pkg::OUT_BITS-1:0] m_tdata;    // token_start[15:0], token_length[31:16]
	logic [1:0]                   m_tuser;    // token_kind[1:0]
	logic                         m_tlast;    // last_of_run

	// Predicted scanner state
	scan_mode_t    scan_mode = SCAN_IDLE;
	bst_pkg::pos_t tok_start = '0;
	bst_pkg::len_t tok_len   = '0;
	bst_pkg::pos_t text_pos  = '0;

	bst_pkg::token_t expected_tokens[$];
	bst_pkg::token_t want;
	int              mismatch_count = 0;
	int              bytes_sent     = 0;

	// Sender burst control
	int         burst_left    = 0;
	int         gap_len       = 0;
	bit         sender_steady = 1'b0;

	// Receiver stall control
	int         rx_hold_left  = 0;
	int         rx_phase_left = 0;
	rx_style_t  rx_style      = RX_FREE;

	int         stuck_cycles;

	byte_stream_tokenizer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic char_class_t classify(input logic [7:0] c);
		if (c == bst_pkg::CHAR_NUL)
			return CC_NUL;
		if (c == bst_pkg::CHAR_QUOTE)
			return CC_QUOTE;
		if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
			return CC_SPACE;
		if (c >= "0" && c <= "9")
			return CC_DIGIT;
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == bst_pkg::CHAR_UNDER)
			return CC_WORD;
		return CC_OTHER;
	endfunction

	// Draw a nonzero byte of the given class
	function automatic logic [7:0] random_of(input char_class_t want_cls);
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (classify(c) != want_cls);
		return c;
	endfunction

	// Any nonzero byte that does not close a string
	function automatic logic [7:0] random_body();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == bst_pkg::CHAR_QUOTE);
		return c;
	endfunction

	task automatic grow_run();
		if (tok_len != LEN_SAT)
			tok_len = tok_len + bst_pkg::len_t'(1);
	endtask

	// Advance the predicted scanner by one byte and queue the tokens it produces
	task automatic scan_byte(input logic [7:0] c);
		bst_pkg::token_t made [2];
		int              n;
		bit              taken;
		char_class_t     cls;
		n = 0;
		taken = 1'b0;
		cls = classify(c);

		// Extend or close the open token
		case (scan_mode)
			SCAN_NUMBER: begin
				if (cls == CC_DIGIT) begin
					grow_run();
					taken = 1'b1;
				end else begin
					made[n] = '{bst_pkg::KIND_LITERAL, bst_pkg::pos_to_start(tok_start),
						tok_len, 1'b0};
					n++;
					scan_mode = SCAN_IDLE;
				end
			end
			SCAN_IDENT: begin
				if (cls == CC_WORD || cls == CC_DIGIT) begin
					grow_run();
					taken = 1'b1;
				end else begin
					made[n] = '{bst_pkg::KIND_IDENT, bst_pkg::pos_to_start(tok_start),
						tok_len, 1'b0};
					n++;
					scan_mode = SCAN_IDLE;
				end
			end
			SCAN_STRING: begin
				if (cls == CC_QUOTE) begin
					made[n] = '{bst_pkg::KIND_LITERAL, bst_pkg::pos_to_start(tok_start),
						tok_len, 1'b0};
					n++;
					scan_mode = SCAN_IDLE;
					taken = 1'b1;
				end else if (cls == CC_NUL) begin
					made[n] = '{bst_pkg::KIND_UNKNOWN, bst_pkg::pos_to_start(tok_start),
						tok_len, 1'b0};
					n++;
					scan_mode = SCAN_IDLE;
				end else begin
					grow_run();
					taken = 1'b1;
				end
			end
			default: ;
		endcase

		// Scan the byte from idle when no open token took it
		if (!taken) begin
			case (cls)
				CC_NUL: begin
					made[n] = '{bst_pkg::KIND_CONTROL, bst_pkg::pos_to_start(text_pos),
						bst_pkg::len_t'(1), 1'b0};
					n++;
				end
				CC_SPACE: ;
				CC_DIGIT: begin
					scan_mode = SCAN_NUMBER;
					tok_start = text_pos;
					tok_len   = bst_pkg::len_t'(1);
				end
				CC_QUOTE: begin
					scan_mode = SCAN_STRING;
					tok_start = text_pos + bst_pkg::pos_t'(1);
					tok_len   = '0;
				end
				CC_WORD: begin
					scan_mode = SCAN_IDENT;
					tok_start = text_pos;
					tok_len   = bst_pkg::len_t'(1);
				end
				default: begin
					made[n] = '{bst_pkg::KIND_UNKNOWN, bst_pkg::pos_to_start(text_pos),
						bst_pkg::len_t'(1), 1'b0};
					n++;
				end
			endcase
		end

		// End of text restarts the offsets
		if (cls == CC_NUL) begin
			scan_mode = SCAN_IDLE;
			tok_start = '0;
			tok_len   = '0;
			text_pos  = '0;
		end else begin
			text_pos = text_pos + bst_pkg::pos_t'(1);
		end

		if (n > 0)
			made[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_tokens.push_back(made[i]);
	endtask

	// Offer one byte in bursts with random gaps unless sender_steady is set; predict once it is accepted
	task automatic send_byte(input logic [7:0] b);
		if (burst_left == 0) begin
			if (gap_len > 0 && !sender_steady) begin
				s_tvalid = 1'b0;
				repeat (gap_len) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
			gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		end
		burst_left--;
		s_tvalid = 1'b1;
		s_tdata  = b;
		do
			@(posedge clk);
		while (!s_tready);
		scan_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Pause the sender until every predicted token has come out
	task automatic sender_drain();
		s_tvalid = 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			send_byte(txt[i]);
	endtask

	// Every character class, two-result bytes, empty and open strings, end of text
	task automatic test_directed_classes();
		send_text("79 _Z0+");
		send_byte(bst_pkg::CHAR_QUOTE);
		send_byte(bst_pkg::CHAR_QUOTE);
		send_byte(bst_pkg::CHAR_QUOTE);
		send_text("a\t");
		send_byte(8'hFF);
		send_text("a");
		send_byte(bst_pkg::CHAR_QUOTE);
		send_text("1x5#");
		send_byte(bst_pkg::CHAR_NUL);
		send_byte(bst_pkg::CHAR_QUOTE);
		send_text("q");
		send_byte(bst_pkg::CHAR_NUL);
		send_text("w");
		send_byte(bst_pkg::CHAR_NUL);
		send_byte(bst_pkg::CHAR_NUL);
		sender_drain();
	endtask

	// Hold the output off while two-result bytes keep arriving
	task automatic test_backpressure();
		sender_steady = 1'b1;
		rx_hold_left  = 300;
		repeat (30) begin
			send_byte(random_of(CC_WORD));
			send_byte(random_of(CC_OTHER));
		end
		sender_steady = 1'b0;
		sender_drain();
	endtask

	// Mostly well-formed token streams with random content, plus raw noise
	task automatic test_random_text();
		int goal;
		int pick;
		int len;
		goal = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				len = $urandom_range(1, 6);
				repeat (len) send_byte(random_of(CC_DIGIT));
			end else if (pick < 40) begin
				send_byte(($urandom_range(0, 4) == 0) ? bst_pkg::CHAR_UNDER
					: random_of(CC_WORD));
				len = $urandom_range(0, 7);
				repeat (len)
					send_byte(($urandom_range(0, 2) == 0) ? random_of(CC_DIGIT)
						: random_of(CC_WORD));
			end else if (pick < 55) begin
				send_byte(bst_pkg::CHAR_QUOTE);
				len = $urandom_range(0, 6);
				repeat (len) send_byte(random_body());
				send_byte(($urandom_range(0, 9) == 0) ? bst_pkg::CHAR_NUL
					: bst_pkg::CHAR_QUOTE);
			end else if (pick < 75) begin
				len = $urandom_range(1, 3);
				repeat (len) send_byte(random_of(CC_SPACE));
			end else if (pick < 83) begin
				send_byte(random_of(CC_OTHER));
			end else if (pick < 86) begin
				send_byte(bst_pkg::CHAR_NUL);
			end else begin
				len = $urandom_range(1, 4);
				repeat (len) send_byte(8'($urandom_range(0, 255)));
			end
		end
		sender_drain();
	endtask

	// Receiver: forced hold-off first, otherwise a stall style that changes per phase
	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				m_tready = 1'b0;
				rx_hold_left--;
			end else begin
				if (rx_phase_left == 0) begin
					rx_style = rx_style_t'($urandom_range(0, 3));
					rx_phase_left = $urandom_range(20, 200);
				end
				rx_phase_left--;
				case (rx_style)
					RX_FREE:   m_tready = 1'b1;
					RX_HALF:   m_tready = 1'($urandom_range(0, 1));
					RX_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
					default:   m_tready = ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Compare each output beat with the oldest predicted token
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_tokens.size() == 0) begin
				$error("unexpected token beat: tdata %h tuser %h tlast %b", m_tdata,
					m_tuser, m_tlast);
				mismatch_count++;
			end else begin
				want = expected_tokens.pop_front();
				if (m_tuser !== want.kind) begin
					$error("token_kind expected %0d got %0d", want.kind, m_tuser);
					mismatch_count++;
				end
				if (m_tdata[15:0] !== want.start) begin
					$error("token_start expected %0d got %0d", want.start, m_tdata[15:0]);
					mismatch_count++;
				end
				if (m_tdata[31:16] !== want.length) begin
					$error("token_length expected %0d got %0d", want.length,
						m_tdata[31:16]);
					mismatch_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last_of_run expected %0d got %0d", want.last, m_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	initial begin
		stuck_cycles = 0;
		while (stuck_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_classes();
		test_backpressure();
		test_random_text();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_tokens.size() != 0) begin
			$error("%0d predicted tokens never arrived", expected_tokens.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
